/* hdl/lkvt_pkg.sv */
// ----------------------------------------------------------------------------
// lkvt_pkg: shared types and constants of the linear key/value table
//
// Field widths, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package lkvt_pkg;

   localparam int FUNC_W      = 2;
   localparam int KEY_W       = 16;
   localparam int VAL_W       = 16;
   localparam int ENTRY_W     = KEY_W + VAL_W;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

endpackage

/* hdl/lkvt_if.sv */
// ----------------------------------------------------------------------------
// lkvt_if: request and response channels of the linear key/value table
//
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lkvt_req_if;
   logic                           valid;
   logic                           ready;
   logic [lkvt_pkg::FUNC_W-1:0]    func;
   logic [lkvt_pkg::KEY_W-1:0]     key;
   logic [lkvt_pkg::VAL_W-1:0]     data_in;

   modport source (output valid, output func, output key, output data_in, input ready);
   modport sink   (input valid, input func, input key, input data_in, output ready);
endinterface

interface lkvt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [lkvt_pkg::VAL_W-1:0]       data_out;
   logic [lkvt_pkg::STATUS_W-1:0]    status;
   logic [lkvt_pkg::COUNT_OUT_W-1:0] entry_count;
   logic                             is_empty;
   logic                             is_full;

   modport source (output valid, output found, output data_out, output status,
                   output entry_count, output is_empty, output is_full, input ready);
   modport sink   (input valid, input found, input data_out, input status,
                   input entry_count, input is_empty, input is_full, output ready);
endinterface

/* hdl/linear_key_value_table.sv */
// ----------------------------------------------------------------------------
// linear_key_value_table: packed key/value table with linear search
//
// Lookup, insert and delete on an unsorted array of up to CAPACITY entries.
// A delete moves the later entries down one slot to keep the array packed.
//
//   Channel  Direction  Carries
//   req_ch   in         func, key, data_in
//   rsp_ch   out        found, data_out, status, entry_count, is_empty, is_full
//
// After a request transfer the scan compares the stored entries in turn until one matches
// and, for a delete that hits, moves the later entries down one slot; then the result is
// loaded. A request is taken only in the idle state, never while one is in progress.
// Reset is synchronous and empties the table; the memory is not cleared.
// The result sits in an output register; a new request is taken while it waits,
// and the next result is held back until the previous one has been taken.
// ----------------------------------------------------------------------------
module linear_key_value_table #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   lkvt_req_if.sink   req_ch,
   lkvt_rsp_if.source rsp_ch
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   lkvt_pkg::state_type state_ff, state_in;

   logic [lkvt_pkg::FUNC_W-1:0] func_ff;
   logic [lkvt_pkg::KEY_W-1:0]  key_ff;
   logic [lkvt_pkg::VAL_W-1:0]  data_ff;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        hit_ff, hit_in;
   logic [lkvt_pkg::VAL_W-1:0]  val_ff, val_in;
   logic [CNT_W-1:0]            count_ff, count_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [lkvt_pkg::VAL_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [lkvt_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [lkvt_pkg::COUNT_OUT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                              rsp_empty_ff, rsp_empty_in;
   logic                              rsp_full_ff, rsp_full_in;

   logic                         req_xfer;
   logic                         go;
   logic                         match;
   logic                         table_full;
   logic [SUM_W-1:0]             idx_p1, idx_p2, cnt_ext;
   logic [31:0]                  count_wide;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [lkvt_pkg::ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]             rd_addr;
   logic [lkvt_pkg::ENTRY_W-1:0] rd_data;

   lkvt_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W),
      .WIDTH  (lkvt_pkg::ENTRY_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == lkvt_pkg::ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign go           = (state_ff == lkvt_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
   assign match        = (rd_data[lkvt_pkg::ENTRY_W-1:lkvt_pkg::VAL_W] == key_ff);
   assign idx_p1       = SUM_W'(idx_ff) + SUM_W'(1);
   assign idx_p2       = SUM_W'(idx_ff) + SUM_W'(2);
   assign cnt_ext      = SUM_W'(count_ff);
   assign table_full   = (count_ff == CNT_W'(CAPACITY));

   // Next state and scan bookkeeping.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      val_in   = val_ff;
      case (state_ff)
         lkvt_pkg::ST_IDLE: begin
            if (req_xfer) begin
               idx_in = '0;
               hit_in = 1'b0;
               if (count_ff == '0) begin
                  state_in = lkvt_pkg::ST_FINISH;
               end else begin
                  state_in = lkvt_pkg::ST_SCAN;
               end
            end
         end
         lkvt_pkg::ST_SCAN: begin
            if (match) begin
               hit_in = 1'b1;
               val_in = rd_data[lkvt_pkg::VAL_W-1:0];
               if ((func_ff == lkvt_pkg::FUNC_DELETE) && (idx_p1 < cnt_ext)) begin
                  state_in = lkvt_pkg::ST_SHIFT;
               end else begin
                  state_in = lkvt_pkg::ST_FINISH;
               end
            end else if (idx_p1 >= cnt_ext) begin
               state_in = lkvt_pkg::ST_FINISH;
            end else begin
               idx_in = IDX_W'(idx_p1);
            end
         end
         lkvt_pkg::ST_SHIFT: begin
            idx_in = IDX_W'(idx_p1);
            if (idx_p2 >= cnt_ext) begin
               state_in = lkvt_pkg::ST_FINISH;
            end
         end
         lkvt_pkg::ST_FINISH: begin
            if (go) begin
               state_in = lkvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkvt_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory control, count update and result.
   always_comb begin
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      count_in      = count_ff;
      rsp_found_in  = hit_ff;
      rsp_data_in   = '0;
      rsp_status_in = lkvt_pkg::STATUS_DONE;
      case (state_ff)
         lkvt_pkg::ST_SCAN: begin
            rd_addr = IDX_W'(idx_p1);
         end
         lkvt_pkg::ST_SHIFT: begin
            rd_addr = IDX_W'(idx_p2);
            wr_en   = 1'b1;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
      case (func_ff)
         lkvt_pkg::FUNC_INSERT: begin
            if (hit_ff) begin
               rsp_status_in = lkvt_pkg::STATUS_DUP;
            end else if (table_full) begin
               rsp_status_in = lkvt_pkg::STATUS_FULL;
            end else begin
               rsp_status_in = lkvt_pkg::STATUS_DONE;
               if (go) begin
                  wr_en    = 1'b1;
                  wr_addr  = IDX_W'(count_ff);
                  wr_data  = {key_ff, data_ff};
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         lkvt_pkg::FUNC_DELETE: begin
            if (hit_ff) begin
               rsp_status_in = lkvt_pkg::STATUS_DONE;
               if (go) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               rsp_status_in = lkvt_pkg::STATUS_ABSENT;
            end
         end
         default: begin
            if (hit_ff) begin
               rsp_status_in = lkvt_pkg::STATUS_DONE;
               rsp_data_in   = val_ff;
            end else begin
               rsp_status_in = lkvt_pkg::STATUS_ABSENT;
            end
         end
      endcase
      count_wide   = 32'(count_in);
      rsp_count_in = count_wide[lkvt_pkg::COUNT_OUT_W-1:0];
      rsp_empty_in = (count_in == '0);
      rsp_full_in  = (count_in == CNT_W'(CAPACITY));
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      val_ff <= val_in;
      if (req_xfer) begin
         func_ff <= req_ch.func;
         key_ff  <= req_ch.key;
         data_ff <= req_ch.data_in;
      end
      if (go) begin
         rsp_found_ff  <= rsp_found_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.data_out    = rsp_data_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.is_empty    = rsp_empty_ff;
   assign rsp_ch.is_full     = rsp_full_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(count_ff) |-> $past(state_ff == lkvt_pkg::ST_FINISH))
      else $error("entry count changed outside the finish step");

   a_shift_delete: assert property (@(posedge clock) disable iff (reset)
      state_ff == lkvt_pkg::ST_SHIFT |-> (func_ff == lkvt_pkg::FUNC_DELETE) && hit_ff)
      else $error("entries moved without a delete hit");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while the previous one is in progress");
`endif

endmodule

/* hdl/lkvt_store.sv */
// ----------------------------------------------------------------------------
// lkvt_store: entry memory of the linear key/value table
//
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkvt_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/linear_key_value_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_key_value_table_checker: result predictor and comparator
//
// Watches both channels of the table. Every accepted request is applied to a
// private copy of the table, which yields the answer the block must return.
// Each accepted response is compared with the oldest waiting answer. The
// module reports the number of failures and of answers still outstanding.
// ----------------------------------------------------------------------------
module linear_key_value_table_checker #(
   parameter int CAPACITY = 16
) (
   input  logic clock,
   input  logic reset,
   lkvt_req_if  req_ch,
   lkvt_rsp_if  rsp_ch,
   output int   error_count,
   output int   outstanding
);

   typedef struct packed {
      logic                             found;
      logic [lkvt_pkg::VAL_W-1:0]       data_out;
      logic [lkvt_pkg::STATUS_W-1:0]    status;
      logic [lkvt_pkg::COUNT_OUT_W-1:0] entry_count;
      logic                             is_empty;
      logic                             is_full;
   } table_answer_type;

   logic [lkvt_pkg::KEY_W-1:0] slot_key   [CAPACITY];
   logic [lkvt_pkg::VAL_W-1:0] slot_value [CAPACITY];
   int                         stored = 0;
   table_answer_type           awaited_answers[$];
   int                         fails = 0;

   function automatic table_answer_type apply_request(
         input logic [lkvt_pkg::FUNC_W-1:0] op,
         input logic [lkvt_pkg::KEY_W-1:0]  k,
         input logic [lkvt_pkg::VAL_W-1:0]  v);
      table_answer_type ans;
      int               hit_slot;
      ans      = '0;
      hit_slot = -1;
      for (int i = 0; i < stored; i++) begin
         if (hit_slot < 0 && slot_key[i] == k) hit_slot = i;
      end
      ans.found = (hit_slot >= 0);
      case (op)
         lkvt_pkg::FUNC_INSERT: begin
            if (hit_slot >= 0) begin
               ans.status = lkvt_pkg::STATUS_DUP;
            end else if (stored >= CAPACITY) begin
               ans.status = lkvt_pkg::STATUS_FULL;
            end else begin
               slot_key[stored]   = k;
               slot_value[stored] = v;
               stored++;
               ans.status = lkvt_pkg::STATUS_DONE;
            end
         end
         lkvt_pkg::FUNC_DELETE: begin
            if (hit_slot >= 0) begin
               for (int i = hit_slot; i + 1 < stored; i++) begin
                  slot_key[i]   = slot_key[i + 1];
                  slot_value[i] = slot_value[i + 1];
               end
               stored--;
               ans.status = lkvt_pkg::STATUS_DONE;
            end else begin
               ans.status = lkvt_pkg::STATUS_ABSENT;
            end
         end
         default: begin
            if (hit_slot >= 0) begin
               ans.data_out = slot_value[hit_slot];
               ans.status   = lkvt_pkg::STATUS_DONE;
            end else begin
               ans.status = lkvt_pkg::STATUS_ABSENT;
            end
         end
      endcase
      ans.entry_count = lkvt_pkg::COUNT_OUT_W'(stored);
      ans.is_empty    = (stored == 0);
      ans.is_full     = (stored >= CAPACITY);
      return ans;
   endfunction

   always @(posedge clock) begin
      table_answer_type want;
      table_answer_type got;
      if (reset) begin
         stored = 0;
         awaited_answers.delete();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.found       = rsp_ch.found;
            got.data_out    = rsp_ch.data_out;
            got.status      = rsp_ch.status;
            got.entry_count = rsp_ch.entry_count;
            got.is_empty    = rsp_ch.is_empty;
            got.is_full     = rsp_ch.is_full;
            if (awaited_answers.size() == 0) begin
               if (fails < 10)
                  $display("%0t: response transfer with no request waiting", $realtime);
               fails++;
            end else begin
               want = awaited_answers.pop_front();
               if (got !== want) begin
                  if (fails < 10)
                     $display({"%0t: mismatch, expected found=%0d data=%h status=%0d ",
                               "count=%0d empty=%0d full=%0d, got found=%0d data=%h ",
                               "status=%0d count=%0d empty=%0d full=%0d"},
                              $realtime, want.found, want.data_out, want.status,
                              want.entry_count, want.is_empty, want.is_full,
                              got.found, got.data_out, got.status,
                              got.entry_count, got.is_empty, got.is_full);
                  fails++;
               end
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            awaited_answers.push_back(apply_request(req_ch.func, req_ch.key,
                                                    req_ch.data_in));
      end
      error_count <= fails;
      outstanding <= awaited_answers.size();
   end

endmodule

/* verif/linear_key_value_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_key_value_table_tb: testbench top of the linear key/value table
//
// A directed sequence covers empty and full tables, duplicate and rejected
// inserts, absent keys, the spare operation code and a delete that packs the
// array. Random traffic then fills and drains the table from a small key
// pool, with random gaps on the request side and stalls on the response side.
// ----------------------------------------------------------------------------
module linear_key_value_table_tb;

   localparam int                          CAPACITY    = 16;
   localparam int                          IDLE_LIMIT  = 4000;
   localparam int                          SETTLE_WAIT = 40;
   localparam int                          POOL_SIZE   = 24;
   localparam logic [lkvt_pkg::FUNC_W-1:0] FUNC_SPARE  = 2'd3;
   localparam int                          MODE_FILL   = 0;
   localparam int                          MODE_DRAIN  = 1;
   localparam int                          MODE_MIXED  = 2;

   logic clock;
   logic reset;
   int   error_count;
   int   outstanding;
   int   quiet_cycles = 0;
   int   stall_left   = 0;
   int   cycle_count  = 0;
   bit   sender_calm  = 1'b0;
   bit   sink_calm    = 1'b0;
   logic [lkvt_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

   lkvt_req_if req_ch();
   lkvt_rsp_if rsp_ch();

   linear_key_value_table #(.CAPACITY(CAPACITY)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   linear_key_value_table_checker #(.CAPACITY(CAPACITY)) table_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) sink_calm <= ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!sink_calm) stall_left <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [lkvt_pkg::FUNC_W-1:0] op,
                               input logic [lkvt_pkg::KEY_W-1:0]  k,
                               input logic [lkvt_pkg::VAL_W-1:0]  v);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.func    <= op;
      req_ch.key     <= k;
      req_ch.data_in <= v;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      gap = sender_calm ? 0 : gap_length();
      if (gap > 0) begin
         req_ch.valid   <= 1'b0;
         req_ch.func    <= lkvt_pkg::FUNC_W'($urandom);
         req_ch.key     <= lkvt_pkg::KEY_W'($urandom);
         req_ch.data_in <= lkvt_pkg::VAL_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_table_answers();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [lkvt_pkg::FUNC_W-1:0] pick_operation(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return FUNC_SPARE;
      case (mode)
         MODE_FILL:  return (r < 60) ? lkvt_pkg::FUNC_INSERT :
                            (r < 80) ? lkvt_pkg::FUNC_LOOKUP : lkvt_pkg::FUNC_DELETE;
         MODE_DRAIN: return (r < 20) ? lkvt_pkg::FUNC_INSERT :
                            (r < 35) ? lkvt_pkg::FUNC_LOOKUP : lkvt_pkg::FUNC_DELETE;
         default:    return (r < 40) ? lkvt_pkg::FUNC_INSERT :
                            (r < 70) ? lkvt_pkg::FUNC_LOOKUP : lkvt_pkg::FUNC_DELETE;
      endcase
   endfunction

   function automatic logic [lkvt_pkg::VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return lkvt_pkg::VAL_W'($urandom);
   endfunction

   initial begin
      int                         mode;
      logic [lkvt_pkg::KEY_W-1:0] k;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.func    <= lkvt_pkg::FUNC_LOOKUP;
      req_ch.key     <= '0;
      req_ch.data_in <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 0; i < 14; i++) key_pool[i + 2] = lkvt_pkg::KEY_W'(1) << i;
      for (int i = 16; i < POOL_SIZE; i++) key_pool[i] = lkvt_pkg::KEY_W'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(lkvt_pkg::FUNC_LOOKUP, '0, '0);
      send_request(lkvt_pkg::FUNC_DELETE, '0, '1);
      send_request(lkvt_pkg::FUNC_INSERT, '0, '0);
      send_request(lkvt_pkg::FUNC_INSERT, '1, '1);
      send_request(lkvt_pkg::FUNC_LOOKUP, '1, '0);
      send_request(lkvt_pkg::FUNC_LOOKUP, '0, '1);
      send_request(lkvt_pkg::FUNC_INSERT, '0, 16'h5A5A);
      send_request(FUNC_SPARE, '1, 16'h1234);
      for (int i = 0; i < 14; i++)
         send_request(lkvt_pkg::FUNC_INSERT, key_pool[i + 2], ~key_pool[i + 2]);
      send_request(lkvt_pkg::FUNC_INSERT, 16'h4000, 16'hBEEF);
      send_request(lkvt_pkg::FUNC_INSERT, '1, 16'h0F0F);
      send_request(lkvt_pkg::FUNC_DELETE, 16'h0010, '0);
      send_request(lkvt_pkg::FUNC_LOOKUP, 16'h2000, '0);
      send_request(lkvt_pkg::FUNC_DELETE, 16'h8000, '0);
      drain_table_answers();

      for (int seg = 0; seg < 13; seg++) begin
         mode        = $urandom_range(MODE_FILL, MODE_MIXED);
         sender_calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else                            k = lkvt_pkg::KEY_W'($urandom);
            send_request(pick_operation(mode), k, pick_value());
         end
         if ($urandom_range(0, 2) == 0) drain_table_answers();
      end

      drain_table_answers();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
